@@ sv/adnp_pkg.sv @@
// adnp_pkg: shared constants, character codes, power-of-ten table and the
// command struct between controller and datapath of the decimal parser.
// No dependencies.
package adnp_pkg;

  // format of the fixed-point result
  localparam int unsigned FRAC_BITS       = 16;
  localparam int unsigned MAX_FRAC_DIGITS = 9;

  // field and accumulator widths
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned INT_W      = 32;
  localparam int unsigned FRAC_ACC_W = 30;
  localparam int unsigned FRAC_CNT_W = 4;
  localparam int unsigned FIXED_W    = 48;
  localparam int unsigned STEP_CNT_W = $clog2(FRAC_BITS + 1);

  // character codes
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;

  // saturation bounds of the 48-bit result and the integer range check
  localparam logic signed [63:0] FIX_MAX    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] FIX_MIN    = 64'shFFFF_8000_0000_0000;
  localparam logic signed [63:0] FIX_LIMIT  = 64'sd1 <<< (47 - FRAC_BITS);
  localparam logic signed [63:0] FIX_NLIMIT = -FIX_LIMIT;

  // controller to datapath commands
  typedef struct packed {
    logic take_char;
    logic div_init;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  // 10^n for the fraction divisor, counts above nine clamp to nine
  function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [FRAC_CNT_W-1:0] n);
    logic [FRAC_ACC_W-1:0] r;
    case (n)
      4'd0:    r = 30'd1;
      4'd1:    r = 30'd10;
      4'd2:    r = 30'd100;
      4'd3:    r = 30'd1000;
      4'd4:    r = 30'd10000;
      4'd5:    r = 30'd100000;
      4'd6:    r = 30'd1000000;
      4'd7:    r = 30'd10000000;
      4'd8:    r = 30'd100000000;
      default: r = 30'd1000000000;
    endcase
    return r;
  endfunction

endpackage

@@ sv/adnp_dp.sv @@
// adnp_dp: character parser state, integer and fraction accumulators,
// restoring fraction divider and result registers.
// Depends on adnp_pkg.
module adnp_dp import adnp_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dp_cmd_t                    cmd_i,
  input  logic [CHAR_W-1:0]          char_code_i,
  output logic                       parse_ok_o,
  output logic signed [INT_W-1:0]    int_value_o,
  output logic signed [FIXED_W-1:0]  fixed_value_o
);

  typedef enum logic [6:0] {
    PH_SPACE    = 7'b0000001,
    PH_PLUS     = 7'b0000010,
    PH_SIGN     = 7'b0000100,
    PH_INT      = 7'b0001000,
    PH_FRAC     = 7'b0010000,
    PH_STOP_OK  = 7'b0100000,
    PH_STOP_BAD = 7'b1000000
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic                   neg_q, neg_d;
  logic [INT_W-1:0]       ia_q, ia_d;
  logic [FRAC_ACC_W-1:0]  fa_q, fa_d;
  logic [FRAC_CNT_W-1:0]  fc_q, fc_d;

  logic                   is_digit, is_space;
  logic [3:0]             digit;
  logic [INT_W-1:0]       ia_x10;
  logic [FRAC_ACC_W-1:0]  fa_x10;

  // character classes
  assign is_digit = (char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE);
  assign is_space = (char_code_i == CH_CR) || (char_code_i == CH_LF) ||
                    (char_code_i == CH_TAB) || (char_code_i == CH_SPACE);
  assign digit    = 4'(char_code_i - CH_ZERO);
  assign ia_x10   = (ia_q << 3) + (ia_q << 1);
  assign fa_x10   = (fa_q << 3) + (fa_q << 1);

  // parser next state
  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    ia_d    = ia_q;
    fa_d    = fa_q;
    fc_d    = fc_q;
    if (cmd_i.finish) begin
      phase_d = PH_SPACE;
      neg_d   = 1'b0;
      ia_d    = '0;
      fa_d    = '0;
      fc_d    = '0;
    end else if (cmd_i.take_char) begin
      case (phase_q)
        PH_SPACE, PH_PLUS, PH_SIGN: begin
          if (phase_q == PH_SPACE && is_space) begin
            phase_d = phase_q;
          end else if (phase_q == PH_SPACE && char_code_i == CH_PLUS) begin
            phase_d = PH_PLUS;
          end else if (phase_q != PH_SIGN && char_code_i == CH_MINUS) begin
            neg_d   = 1'b1;
            phase_d = PH_SIGN;
          end else if (is_digit) begin
            ia_d    = INT_W'(digit);
            phase_d = PH_INT;
          end else begin
            phase_d = PH_STOP_BAD;
          end
        end
        PH_INT: begin
          if (is_digit) begin
            ia_d = ia_x10 + INT_W'(digit);
          end else if (char_code_i == CH_DOT) begin
            phase_d = PH_FRAC;
          end else begin
            phase_d = PH_STOP_OK;
          end
        end
        PH_FRAC: begin
          if (is_digit) begin
            // digits past the limit are consumed but not kept
            if (fc_q < FRAC_CNT_W'(MAX_FRAC_DIGITS)) begin
              fa_d = fa_x10 + FRAC_ACC_W'(digit);
              fc_d = fc_q + 4'd1;
            end
          end else begin
            phase_d = PH_STOP_OK;
          end
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SPACE;
      neg_q   <= 1'b0;
      ia_q    <= '0;
      fa_q    <= '0;
      fc_q    <= '0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      ia_q    <= ia_d;
      fa_q    <= fa_d;
      fc_q    <= fc_d;
    end
  end

  // restoring divider: one quotient bit of fraction*2^FRAC_BITS/10^n per step
  logic [FRAC_ACC_W-1:0] rem_q, div_q;
  logic [FRAC_BITS-1:0]  quo_q;
  logic [FRAC_ACC_W:0]   rem_sh, rem_sub;
  logic                  q_bit;

  assign rem_sh  = {rem_q, 1'b0};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign q_bit   = ~rem_sub[FRAC_ACC_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= fa_q;
      div_q <= pow10(fc_q);
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= q_bit ? rem_sub[FRAC_ACC_W-1:0] : rem_sh[FRAC_ACC_W-1:0];
      quo_q <= FRAC_BITS'({quo_q, q_bit});
    end
  end

  // final signed integer and saturated fixed-point value
  logic                   ok;
  logic [INT_W-1:0]       ival;
  logic signed [63:0]     iv64, ishift, fq64, vsum, vsat;

  assign ok     = (phase_q == PH_INT) || (phase_q == PH_FRAC) || (phase_q == PH_STOP_OK);
  assign ival   = neg_q ? (INT_W'(0) - ia_q) : ia_q;
  assign iv64   = {{(64-INT_W){ival[INT_W-1]}}, ival};
  assign ishift = iv64 <<< FRAC_BITS;
  assign fq64   = {{(64-FRAC_BITS){1'b0}}, quo_q};
  assign vsum   = neg_q ? (ishift - fq64) : (ishift + fq64);

  always_comb begin
    if (iv64 >= FIX_LIMIT) begin
      vsat = FIX_MAX;
    end else if (iv64 < FIX_NLIMIT) begin
      vsat = FIX_MIN;
    end else if (vsum > FIX_MAX) begin
      vsat = FIX_MAX;
    end else if (vsum < FIX_MIN) begin
      vsat = FIX_MIN;
    end else begin
      vsat = vsum;
    end
  end

  // result registers
  logic                      ok_q;
  logic signed [INT_W-1:0]   int_q;
  logic signed [FIXED_W-1:0] fix_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      ok_q  <= ok;
      int_q <= ok ? signed'(ival) : '0;
      fix_q <= ok ? vsat[FIXED_W-1:0] : '0;
    end
  end

  assign parse_ok_o    = ok_q;
  assign int_value_o   = int_q;
  assign fixed_value_o = fix_q;

endmodule

@@ sv/adnp_ctrl.sv @@
// adnp_ctrl: sequencer for the decimal parser: character intake, divider
// steps, result hand-off and the output valid flag.
// Depends on adnp_pkg.
module adnp_ctrl import adnp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    end_of_string_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_RUN  = 4'b0001,
    ST_INIT = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic [STEP_CNT_W-1:0]  cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic                   accept;

  // command decode
  assign in_ready_o      = (state_q == ST_RUN);
  assign accept          = in_valid_i && in_ready_o;
  assign cmd_o.take_char = accept;
  assign cmd_o.div_init  = (state_q == ST_INIT);
  assign cmd_o.div_step  = (state_q == ST_DIV);
  assign cmd_o.finish    = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_RUN: begin
        if (accept && end_of_string_i) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cnt_d = cnt_q + STEP_CNT_W'(1);
        if (cnt_q == STEP_CNT_W'(FRAC_BITS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (cmd_o.finish) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // a final character always starts a division
  a_eos_to_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && end_of_string_i) |=> (state_q == ST_INIT))
    else $error("final character did not start the divider");

  // divider step count stays in range
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q < STEP_CNT_W'(FRAC_BITS)))
    else $error("divider step count out of range");

  // a new result appears only after a finish command
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.finish))
    else $error("result valid without finish");

  // a waiting result is not overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_o.finish)
    else $error("result overwritten while stalled");

endmodule

@@ sv/ascii_decimal_number_parser_top.sv @@
// ascii_decimal_number_parser_top: ASCII decimal string to integer and
// fixed-point converter. Depends on adnp_pkg, adnp_ctrl and adnp_dp.
//
// Usage
//   Input channel (in_valid_i/in_ready_o): one character per item in
//   char_code_i, end_of_string_i set on the last character of a string.
//   Output channel (out_valid_o/out_ready_i): one result item per string:
//   parse_ok_o, int_value_o and fixed_value_o (FRAC_BITS fraction bits).
//   Characters are taken one per cycle while in_ready_o is high. After the
//   final character the fraction divider runs: one setup step, FRAC_BITS
//   quotient-bit steps of the restoring divider, and one step to form the
//   result. in_ready_o is low while the divider runs and until the result
//   has been formed.
//   The result sits in an output register, so the next string is accepted
//   while it waits. If the receiver stalls with a result still held, the
//   following result waits in the divider until the register frees up.
//   Reset clears the parser state and drops out_valid_o.
module ascii_decimal_number_parser_top import adnp_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [CHAR_W-1:0]          char_code_i,
  input  logic                       end_of_string_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       parse_ok_o,
  output logic signed [INT_W-1:0]    int_value_o,
  output logic signed [FIXED_W-1:0]  fixed_value_o
);

  dp_cmd_t cmd;

  // sequencer
  adnp_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .end_of_string_i (end_of_string_i),
    .in_ready_o      (in_ready_o),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cmd_o           (cmd)
  );

  // parser, divider and result registers
  adnp_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .char_code_i   (char_code_i),
    .parse_ok_o    (parse_ok_o),
    .int_value_o   (int_value_o),
    .fixed_value_o (fixed_value_o)
  );

endmodule
